/* hw/rtl/process_state_queues_macros.svh */
// Assertion macros shared by the process state queue RTL.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef PROCESS_STATE_QUEUES_MACROS_SVH
`define PROCESS_STATE_QUEUES_MACROS_SVH

// Holds at every clock edge outside reset.
`define PSQ_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define PSQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/psq_pkg.sv */
// Package for the process state queues: sizes, codes and record types.
// No dependencies; used by psq_cell and process_state_queues.
package psq_pkg;

    localparam int ENTRIES   = 32;
    localparam int ID_BITS   = 8;
    localparam int PRIO_BITS = 4;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int OCC_W     = 6;

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_FIND   = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    // queue codes, also the search order
    localparam logic [1:0] Q_READY        = 2'd0;
    localparam logic [1:0] Q_READY_SUSP   = 2'd1;
    localparam logic [1:0] Q_BLOCKED      = 2'd2;
    localparam logic [1:0] Q_BLOCKED_SUSP = 2'd3;

    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        logic [PRIO_BITS-1:0] prio;
        logic [1:0]           queue;
        logic                 cls;
    } t_psq_pay;

    typedef struct packed {
        logic     valid;
        t_psq_pay pay;
    } t_psq_rec;

    typedef struct packed {
        logic [1:0] req;
        t_psq_pay   pay;
    } t_psq_cmd;

    // phase strobes broadcast to every cell
    typedef struct packed {
        logic cmp;
        logic apply_ins;
        logic apply_rm;
    } t_psq_ctl;

endpackage

/* hw/rtl/psq_cell.sv */
// One slot of the record chain: holds a record, compares it with the request,
// and shifts toward or away from its neighbors. Depends on psq_pkg.
module psq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  psq_pkg::t_psq_cmd  i_cmd,
    input  psq_pkg::t_psq_ctl  i_ctl,
    input  psq_pkg::t_psq_rec  i_left,
    input  logic               i_left_ins,
    input  psq_pkg::t_psq_rec  i_right,
    input  logic               i_rm_shift,
    output psq_pkg::t_psq_rec  o_rec,
    output logic               o_hit,
    output logic               o_ins
);
    import psq_pkg::*;

    logic     r_valid;
    t_psq_pay r_pay;
    logic     r_hit;
    logic     r_ins;
    logic     n_hit;
    logic     n_ins;
    t_psq_rec n_rec;
    t_psq_rec w_cur;

    assign w_cur = '{valid: r_valid, pay: r_pay};

    always_comb begin
        n_hit = r_valid && (r_pay.id == i_cmd.pay.id);
        // new record goes ahead of this one
        n_ins = r_valid && ((r_pay.queue > i_cmd.pay.queue) ||
                ((i_cmd.pay.queue < Q_BLOCKED) && (r_pay.queue == i_cmd.pay.queue) &&
                 (r_pay.prio < i_cmd.pay.prio)));
    end

    always_comb begin
        n_rec = w_cur;
        if (i_ctl.apply_ins) begin
            if (i_left_ins) begin
                n_rec = i_left;
            end else if (r_ins || (!r_valid && i_left.valid)) begin
                n_rec = '{valid: 1'b1, pay: i_cmd.pay};
            end
        end
        if (i_ctl.apply_rm && i_rm_shift) begin
            n_rec = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_rec.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pay <= n_rec.pay;
        if (i_ctl.cmp) begin
            r_hit <= n_hit;
            r_ins <= n_ins;
        end
    end

    assign o_rec = w_cur;
    assign o_hit = r_hit;
    assign o_ins = r_ins;

endmodule

/* hw/rtl/process_state_queues.sv */
// Process state queues, top level: request control, chain of slot cells, result
// register. Depends on psq_pkg, psq_cell and process_state_queues_macros.svh.
//
// Usage:
//   Request channel i_in_valid / o_in_stall carries req_type (insert, remove by
//   id, find by id), proc_id, prio, run_state, is_suspended and proc_class.
//   Result channel o_out_valid / i_out_stall returns status, found_queue,
//   found_prio, found_class and occupancy, one result per request, in order.
//   Records sit packed in a row of ENTRIES cells in search order: ready,
//   ready-suspended, blocked, blocked-suspended; ready queues by priority.
//   A request passes through accept, compare and apply: in the compare cycle
//   every cell checks its record against the request; in the apply step the
//   row may shift by one slot and the result is loaded. o_in_stall is high in
//   the compare and apply states, so a new request is taken only after the
//   last one has left apply. The result is registered at the end of apply.
//   If the receiver stalls with a result still held, the apply step waits;
//   the held result stays stable while stalled.
//   Synchronous reset empties all slots at once and drops any pending result.
`include "process_state_queues_macros.svh"

module process_state_queues (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_req_type,
    input  logic [7:0]                        i_proc_id,
    input  logic [3:0]                        i_prio,
    input  logic                              i_run_state,
    input  logic                              i_is_suspended,
    input  logic                              i_proc_class,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_status,
    output logic [1:0]                        o_found_queue,
    output logic [3:0]                        o_found_prio,
    output logic                              o_found_class,
    output logic [psq_pkg::OCC_W-1:0]         o_occupancy
);
    import psq_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CMP   = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    t_psq_cmd         r_cmd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic [1:0]       r_status;
    logic [1:0]       r_fq;
    logic [3:0]       r_fp;
    logic             r_fc;
    logic [OCC_W-1:0] r_occ;

    t_psq_ctl           w_ctl;
    t_psq_rec           w_rec [ENTRIES];
    logic [ENTRIES-1:0] w_hit;
    logic [ENTRIES-1:0] w_ins;
    logic [ENTRIES-1:0] w_valid;
    logic [ENTRIES-1:0] w_first;
    logic [ENTRIES-1:0] w_ge;
    logic               w_accept;
    logic               w_commit;
    logic               w_full;
    logic               w_any;
    t_psq_pay           w_sel;
    logic [1:0]         n_status;

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_commit = (r_state == S_APPLY) && (!r_out_valid || !i_out_stall);
    assign w_full   = (r_count == CNT_W'(ENTRIES));

    // first match in search order, and every slot at or after it
    assign w_first = w_hit & (~w_hit + ENTRIES'(1));
    assign w_ge    = ~(w_first - ENTRIES'(1));
    assign w_any   = |w_hit;

    always_comb begin
        w_ctl.cmp       = (r_state == S_CMP);
        w_ctl.apply_ins = w_commit && (r_cmd.req == REQ_INSERT) && !w_full;
        w_ctl.apply_rm  = w_commit && (r_cmd.req == REQ_REMOVE) && w_any;
    end

    always_comb begin
        w_sel = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_first[i]) begin
                w_sel = w_sel | w_rec[i].pay;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            psq_pkg::t_psq_rec w_left;
            psq_pkg::t_psq_rec w_right;
            logic              w_left_ins;
            if (g == 0) begin : g_head
                // head sees a valid neighbor that never shifts
                assign w_left     = '{valid: 1'b1, pay: '0};
                assign w_left_ins = 1'b0;
            end else begin : g_body
                assign w_left     = w_rec[g-1];
                assign w_left_ins = w_ins[g-1];
            end
            if (g == ENTRIES - 1) begin : g_tail
                assign w_right = '0;
            end else begin : g_inner
                assign w_right = w_rec[g+1];
            end
            psq_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cmd      (r_cmd),
                .i_ctl      (w_ctl),
                .i_left     (w_left),
                .i_left_ins (w_left_ins),
                .i_right    (w_right),
                .i_rm_shift (w_ge[g]),
                .o_rec      (w_rec[g]),
                .o_hit      (w_hit[g]),
                .o_ins      (w_ins[g])
            );
            assign w_valid[g] = w_rec[g].valid;
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_CMP;
            S_CMP:   n_state = S_APPLY;
            S_APPLY: if (w_commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_status = STATUS_OK;
        case (r_cmd.req)
            REQ_INSERT: begin
                if (w_full) begin
                    n_status = STATUS_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            REQ_REMOVE: begin
                if (!w_any) begin
                    n_status = STATUS_NOT_FOUND;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            REQ_FIND: begin
                if (!w_any) begin
                    n_status = STATUS_NOT_FOUND;
                end
            end
            default: n_status = STATUS_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= w_commit || (r_out_valid && i_out_stall);
            if (w_commit) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd.req       <= i_req_type;
            r_cmd.pay.id    <= i_proc_id[ID_BITS-1:0];
            r_cmd.pay.prio  <= i_prio[PRIO_BITS-1:0];
            r_cmd.pay.queue <= {i_run_state, i_is_suspended};
            r_cmd.pay.cls   <= i_proc_class;
        end
        if (w_commit) begin
            r_status <= n_status;
            r_occ    <= OCC_W'(n_count);
            if (((r_cmd.req == REQ_REMOVE) || (r_cmd.req == REQ_FIND)) && w_any) begin
                r_fq <= w_sel.queue;
                r_fp <= 4'(w_sel.prio);
                r_fc <= w_sel.cls;
            end else begin
                r_fq <= Q_READY;
                r_fp <= '0;
                r_fc <= 1'b0;
            end
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_queue = r_fq;
    assign o_found_prio  = r_fp;
    assign o_found_class = r_fc;
    assign o_occupancy   = r_occ;

    `PSQ_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(ENTRIES), "record count above capacity")
    `PSQ_ASSERT_ALWAYS(a_count_matches, $countones(w_valid) == r_count, "valid slots differ from count")
    `PSQ_ASSERT_ALWAYS(a_slots_packed, ((w_valid + ENTRIES'(1)) & w_valid) == '0, "valid slots not packed")
    `PSQ_ASSERT_IMPLY(a_first_onehot, r_state == S_APPLY, $onehot0(w_first), "first match not unique")
    `PSQ_ASSERT_NEXT(a_apply_holds, (r_state == S_APPLY) && !w_commit, r_state == S_APPLY, "apply dropped while result held")

endmodule

/* verif/tb.sv */
// Testbench for process_state_queues: directed and random insert/remove/find requests,
// checked against a behavioral queue model kept in this file. Depends on psq_pkg and process_state_queues.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psq_pkg::*;

    localparam logic [1:0] REQ_UNUSED     = 2'd3;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 8;
    localparam int         MAX_PRINTED    = 50;

    typedef struct packed {
        logic [1:0]       status;
        logic [1:0]       queue;
        logic [3:0]       prio;
        logic             cls;
        logic [OCC_W-1:0] occ;
    } t_queue_result;

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             i_in_valid     = 1'b0;
    logic [1:0]       i_req_type     = '0;
    logic [7:0]       i_proc_id      = '0;
    logic [3:0]       i_prio         = '0;
    logic             i_run_state    = 1'b0;
    logic             i_is_suspended = 1'b0;
    logic             i_proc_class   = 1'b0;
    logic             i_out_stall    = 1'b0;
    logic             o_in_stall;
    logic             o_out_valid;
    logic [1:0]       o_status;
    logic [1:0]       o_found_queue;
    logic [3:0]       o_found_prio;
    logic             o_found_class;
    logic [OCC_W-1:0] o_occupancy;

    // behavioral copy of the record row, in search order
    t_psq_pay      proc_list[$];
    t_queue_result expected_results[$];
    t_queue_result head_result;

    bit send_idle_on     = 1'b1;
    bit recv_idle_on     = 1'b1;
    bit hold_off_request = 1'b0;
    int hold_left        = 0;
    int stall_left       = 0;
    int idle_cycles      = 0;

    int error_count = 0;
    int n_requests  = 0;
    int n_checked   = 0;
    int n_inserts   = 0;
    int n_full      = 0;
    int n_hits      = 0;
    int n_misses    = 0;
    int n_unused    = 0;
    int max_occ     = 0;

    process_state_queues u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_proc_id      (i_proc_id),
        .i_prio         (i_prio),
        .i_run_state    (i_run_state),
        .i_is_suspended (i_is_suspended),
        .i_proc_class   (i_proc_class),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_found_queue  (o_found_queue),
        .o_found_prio   (o_found_prio),
        .o_found_class  (o_found_class),
        .o_occupancy    (o_occupancy)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Applies one request to the record row and returns the result it must produce.
    function automatic t_queue_result queue_apply(input logic [1:0] rq, input logic [7:0] id,
                                                  input logic [3:0] pr, input logic rs,
                                                  input logic su, input logic cl);
        t_queue_result res;
        t_psq_pay      rec;
        logic [1:0]    q;
        int            pos;
        res = '0;
        q   = {rs, su};
        case (rq)
            REQ_INSERT: begin
                if (proc_list.size() >= ENTRIES) begin
                    res.status = STATUS_FULL;
                    n_full++;
                end else begin
                    pos = proc_list.size();
                    // ready queues sort by priority, blocked queues append
                    for (int i = 0; i < proc_list.size(); i++) begin
                        if (proc_list[i].queue > q ||
                            (q < Q_BLOCKED && proc_list[i].queue == q &&
                             proc_list[i].prio < pr)) begin
                            pos = i;
                            break;
                        end
                    end
                    rec.id    = id;
                    rec.prio  = pr;
                    rec.queue = q;
                    rec.cls   = cl;
                    proc_list.insert(pos, rec);
                    n_inserts++;
                end
            end
            REQ_REMOVE, REQ_FIND: begin
                pos = -1;
                for (int i = 0; i < proc_list.size(); i++) begin
                    if (pos < 0 && proc_list[i].id == id) pos = i;
                end
                if (pos < 0) begin
                    res.status = STATUS_NOT_FOUND;
                    n_misses++;
                end else begin
                    res.queue = proc_list[pos].queue;
                    res.prio  = proc_list[pos].prio;
                    res.cls   = proc_list[pos].cls;
                    n_hits++;
                    if (rq == REQ_REMOVE) proc_list.delete(pos);
                end
            end
            default: begin
                n_unused++;
            end
        endcase
        res.occ = OCC_W'(proc_list.size());
        if (proc_list.size() > max_occ) max_occ = proc_list.size();
        return res;
    endfunction

    // Ids already held with chance hit_pct, else a small pool (for duplicates) or any id.
    function automatic logic [7:0] pick_id(input int hit_pct);
        if (proc_list.size() > 0 && $urandom_range(0, 99) < hit_pct)
            return proc_list[$urandom_range(0, proc_list.size() - 1)].id;
        if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 15));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("mismatch result %0d %s: want %0d got %0d", n_checked, what, want, got);
    endtask

    task automatic send_request(input logic [1:0] rq, input logic [7:0] id,
                                input logic [3:0] pr, input logic rs, input logic su,
                                input logic cl);
        int gap;
        @(negedge i_clk);
        if (send_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= rq;
        i_proc_id      <= id;
        i_prio         <= pr;
        i_run_state    <= rs;
        i_is_suspended <= su;
        i_proc_class   <= cl;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(queue_apply(rq, id, pr, rs, su, cl));
        n_requests++;
    endtask

    task automatic send_random(input int insert_pct);
        int         r;
        logic [1:0] rq;
        r = $urandom_range(0, 99);
        if (r < 3) rq = REQ_UNUSED;
        else if (r < 3 + insert_pct) rq = REQ_INSERT;
        else if ($urandom_range(0, 2) != 0) rq = REQ_REMOVE;
        else rq = REQ_FIND;
        send_request(rq, pick_id(rq == REQ_INSERT ? 10 : 75), 4'($urandom_range(0, 15)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
    endtask

    task automatic wait_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_request(REQ_FIND,    8'h00, 4'h0, 1'b0, 1'b0, 1'b0);  // empty store
        send_request(REQ_REMOVE,  8'hff, 4'hf, 1'b1, 1'b1, 1'b1);
        send_request(REQ_INSERT,  8'h00, 4'h0, 1'b0, 1'b0, 1'b0);
        send_request(REQ_INSERT,  8'hff, 4'hf, 1'b0, 1'b0, 1'b1);
        send_request(REQ_INSERT,  8'ha5, 4'hf, 1'b0, 1'b0, 1'b0);  // ties keep arrival order
        send_request(REQ_INSERT,  8'h5a, 4'h7, 1'b0, 1'b1, 1'b1);
        send_request(REQ_INSERT,  8'h3c, 4'h3, 1'b1, 1'b0, 1'b1);
        send_request(REQ_INSERT,  8'hc3, 4'hf, 1'b1, 1'b1, 1'b0);
        send_request(REQ_INSERT,  8'h00, 4'h9, 1'b1, 1'b0, 1'b0);  // duplicate id, blocked
        send_request(REQ_INSERT,  8'h11, 4'hf, 1'b0, 1'b1, 1'b0);  // new head of ready-susp
        send_request(REQ_FIND,    8'ha5, 4'h0, 1'b0, 1'b0, 1'b0);
        send_request(REQ_FIND,    8'hc3, 4'h0, 1'b0, 1'b0, 1'b0);
        send_request(REQ_REMOVE,  8'h00, 4'h0, 1'b0, 1'b0, 1'b0);  // first match only
        send_request(REQ_FIND,    8'h00, 4'h0, 1'b0, 1'b0, 1'b0);
        send_request(REQ_REMOVE,  8'h00, 4'h0, 1'b0, 1'b0, 1'b0);
        send_request(REQ_REMOVE,  8'h00, 4'h0, 1'b0, 1'b0, 1'b0);
        send_request(REQ_UNUSED,  8'hff, 4'hf, 1'b1, 1'b1, 1'b1);
        send_request(REQ_REMOVE,  8'hff, 4'h0, 1'b0, 1'b0, 1'b0);
        send_request(REQ_FIND,    8'h5a, 4'h0, 1'b0, 1'b0, 1'b0);
        send_request(REQ_INSERT,  8'h7e, 4'h0, 1'b0, 1'b0, 1'b1);
        send_request(REQ_FIND,    8'h11, 4'h0, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_fill_and_overflow();
        while (proc_list.size() < ENTRIES) send_random(100);
        repeat (4) send_random(100);
        repeat (6) send_random(0);
        repeat (4) send_random(100);
    endtask

    // Receiver holds off while the sender keeps offering, so the block backs up.
    task automatic test_receiver_hold();
        send_idle_on     = 1'b0;
        recv_idle_on     = 1'b0;
        hold_off_request = 1'b1;
        repeat (40) send_random(50);
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        wait_until_drained();
        repeat (20) send_random(50);
        wait_until_drained();
    endtask

    // Alternating insert-heavy and remove-heavy stretches sweep full to empty.
    task automatic test_random_sweep(input int chunks);
        for (int c = 0; c < chunks; c++) begin
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            repeat (100) send_random((c % 2 == 0) ? 70 : 15);
        end
    endtask

    task automatic test_steady_stream(input int count);
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        repeat (count) send_random(40);
    endtask

    // receiver side: random stall bursts plus the long hold
    always @(negedge i_clk) begin
        if (hold_off_request) begin
            hold_left        = HOLD_CYCLES;
            hold_off_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (recv_idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 14);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 0, 1);
            end else begin
                head_result = expected_results.pop_front();
                if (o_status !== head_result.status)
                    report_mismatch("status", int'(head_result.status), int'(o_status));
                if (o_found_queue !== head_result.queue)
                    report_mismatch("found_queue", int'(head_result.queue),
                                    int'(o_found_queue));
                if (o_found_prio !== head_result.prio)
                    report_mismatch("found_prio", int'(head_result.prio), int'(o_found_prio));
                if (o_found_class !== head_result.cls)
                    report_mismatch("found_class", int'(head_result.cls),
                                    int'(o_found_class));
                if (o_occupancy !== head_result.occ)
                    report_mismatch("occupancy", int'(head_result.occ), int'(o_occupancy));
            end
            n_checked++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_fill_and_overflow();
        test_receiver_hold();
        test_sender_pause();
        test_random_sweep(14);
        test_steady_stream(400);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch("results never delivered", 0, expected_results.size());

        $display("summary: %0d requests, %0d results, %0d inserts, %0d rejected as full",
                 n_requests, n_checked, n_inserts, n_full);
        $display("summary: %0d id hits, %0d misses, %0d unused codes, peak occupancy %0d",
                 n_hits, n_misses, n_unused, max_occ);
        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/psq_pkg.sv
hw/rtl/psq_cell.sv
hw/rtl/process_state_queues.sv
verif/tb.sv
